// ===== hdl/qspe_pkg.sv =====
// Package: shared types and constants of the shortest path engine.
package qspe_pkg;

   localparam int NODE_W  = 10;
   localparam int EDGE_W  = 13;
   localparam int LINK_W  = 14;
   localparam int DIST_W  = 30;
   localparam int COST_W  = 16;
   localparam int COUNT_W = 11;
   localparam int NODES   = 1024;
   localparam int EDGES   = 8192;

   // 127/3 = 42 = 0x2A repeated as 0x2A2A2A2A, which fits the 30-bit distance
   localparam logic [DIST_W-1:0] INIT_DIST = 30'd707406378;

   localparam logic [1:0] OP_ADD   = 2'd0;
   localparam logic [1:0] OP_SOLVE = 2'd1;
   localparam logic [1:0] OP_QUERY = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   localparam logic [0:0] REG_SOURCE = 1'd0;
   localparam logic [0:0] REG_COUNT  = 1'd1;

   typedef struct packed {
      logic [1:0]        opcode;
      logic [NODE_W-1:0] edge_from;
      logic [NODE_W-1:0] edge_to;
      logic [COST_W-1:0] edge_weight;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0] query_node;
      logic [DIST_W-1:0] distance;
      logic              reachable;
      logic              table_full;
   } rsp_type;

   // Saturating relax candidate: dist + cost clipped to INIT_DIST
   function automatic logic [DIST_W-1:0] sat_add(input logic [DIST_W-1:0] d,
                                                 input logic [COST_W-1:0] c);
      logic [DIST_W:0] s;
      s = {1'b0, d} + {{(DIST_W-COST_W+1){1'b0}}, c};
      if (s > {1'b0, INIT_DIST}) sat_add = INIT_DIST;
      else                       sat_add = s[DIST_W-1:0];
   endfunction

endpackage

// ===== hdl/queue_shortest_path_engine_unit.sv =====
// Top level: SPFA shortest path engine with edge store, queue and sequencer.
//
// Add-edge writes the new edge at the head of its source's list, and query
// reads back one distance. Clear sweeps the 1024 list heads one entry a cycle.
// Solve first sweeps all 1024 nodes (clear queued flags, set active distances),
// seeds the queue with the source, then for each popped node reads its list head
// and distance and for each out-edge reads the edge, forms the candidate and
// relaxes the target, until it finds the queue empty. All relaxation runs on one
// shared saturating adder/comparator and memories with one read and one write
// port. busy stays high for the whole item. A result (query reply or dropped-edge
// report) is shown for one cycle with rsp_valid; the receiver cannot stall it.
// After reset the head table is cleared in a pass over all 1024 heads during
// which busy is high; configuration writes are taken at any time the block is idle.
module queue_shortest_path_engine_unit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  qspe_pkg::req_type    req_data,
   output logic                 rsp_valid,
   output qspe_pkg::rsp_type    rsp_data,
   input  logic                 csr_psel,
   input  logic                 csr_penable,
   input  logic                 csr_pwrite,
   input  logic [2:0]           csr_paddr,
   input  logic [31:0]          csr_pwdata,
   output logic [31:0]          csr_prdata,
   output logic                 csr_pready
);
   localparam int NW = qspe_pkg::NODE_W;
   localparam int LW = qspe_pkg::LINK_W;
   localparam int EW = qspe_pkg::EDGE_W;
   localparam int DW = qspe_pkg::DIST_W;

   localparam logic [3:0] S_CLR   = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_ADD   = 4'd2;
   localparam logic [3:0] S_QRY   = 4'd3;
   localparam logic [3:0] S_QRY2  = 4'd4;
   localparam logic [3:0] S_INIT  = 4'd5;
   localparam logic [3:0] S_POP   = 4'd6;
   localparam logic [3:0] S_POPD  = 4'd7;
   localparam logic [3:0] S_HEAD  = 4'd8;
   localparam logic [3:0] S_EDGE  = 4'd9;
   localparam logic [3:0] S_TGT   = 4'd10;
   localparam logic [3:0] S_RELAX = 4'd11;
   localparam logic [3:0] S_ADD2  = 4'd12;
   localparam logic [3:0] S_SRC   = 4'd13;
   localparam logic [3:0] S_LINK  = 4'd14;

   logic [NW-1:0]                 source_ff;
   logic [qspe_pkg::COUNT_W-1:0]  count_ff;
   logic [qspe_pkg::COUNT_W-1:0]  n_act;

   qspe_csr u_csr (
      .clock, .reset, .csr_psel, .csr_penable, .csr_pwrite, .csr_paddr,
      .csr_pwdata, .csr_prdata, .csr_pready, .source_ff, .count_ff
   );
   assign n_act = (count_ff > qspe_pkg::COUNT_W'(qspe_pkg::NODES)) ?
                  qspe_pkg::COUNT_W'(qspe_pkg::NODES) : count_ff;

   // memories
   logic [LW-1:0] head_mem [qspe_pkg::NODES];
   logic [LW-1:0] link_mem [qspe_pkg::EDGES];
   logic [NW-1:0] tgt_mem  [qspe_pkg::EDGES];
   logic [15:0]   cost_mem [qspe_pkg::EDGES];
   logic [DW-1:0] dist_mem [qspe_pkg::NODES];
   logic          flag_mem [qspe_pkg::NODES];
   logic [NW-1:0] queue_mem[qspe_pkg::NODES];

   logic [3:0]    state_ff;
   qspe_pkg::req_type req_ff;
   logic [NW:0]   sweep_ff;
   logic [LW-1:0] edges_ff;
   logic [NW-1:0] rd_ff, wr_ff, now_ff;
   logic [NW:0]   fill_ff;
   logic [LW-1:0] link_ff, head_rd_ff, link_rd_ff;
   logic [DW-1:0] dnow_ff, dist_rd_ff, cand_ff;
   logic [15:0]   cost_rd_ff;
   logic [NW-1:0] tgt_rd_ff, q_rd_ff;
   logic          flag_rd_ff;
   logic          rsp_valid_ff;
   qspe_pkg::rsp_type rsp_ff;

   // shared read addresses
   logic [NW-1:0] head_ra, dist_ra;
   logic [EW-1:0] edge_ra;
   always_comb begin
      head_ra = req_ff.edge_from;
      dist_ra = req_ff.edge_from;
      edge_ra = link_ff[EW-1:0] - EW'(1);
      unique case (state_ff)
         S_POPD, S_HEAD: begin head_ra = now_ff; dist_ra = now_ff; end
         S_EDGE, S_TGT, S_RELAX: dist_ra = tgt_rd_ff;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      head_rd_ff <= head_mem[head_ra];
      dist_rd_ff <= dist_mem[dist_ra];
      flag_rd_ff <= flag_mem[tgt_rd_ff];
      link_rd_ff <= link_mem[edge_ra];
      tgt_rd_ff  <= (state_ff == S_EDGE) ? tgt_mem[edge_ra] : tgt_rd_ff;
      cost_rd_ff <= cost_mem[edge_ra];
      q_rd_ff    <= queue_mem[rd_ff];
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   logic link_ok;
   assign link_ok = (link_ff != '0) && (link_ff <= LW'(qspe_pkg::EDGES));

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         state_ff <= S_CLR;
         sweep_ff <= '0;
         edges_ff <= '0;
      end else begin
         // strobe a reply or a dropped-edge report for exactly one cycle
         rsp_valid_ff <= (state_ff == S_QRY2) ||
                         (state_ff == S_ADD2 && edges_ff >= LW'(qspe_pkg::EDGES));
         unique case (state_ff)
            S_CLR: begin
               head_mem[sweep_ff[NW-1:0]] <= '0;
               sweep_ff <= sweep_ff + 1'b1;
               if (sweep_ff[NW-1:0] == '1) begin
                  state_ff <= S_IDLE;
                  edges_ff <= '0;
               end
            end
            S_IDLE: if (start) begin
               req_ff   <= req_data;
               sweep_ff <= '0;
               unique case (req_data.opcode)
                  qspe_pkg::OP_ADD:   state_ff <= S_ADD;
                  qspe_pkg::OP_SOLVE: state_ff <= S_INIT;
                  qspe_pkg::OP_QUERY: state_ff <= S_QRY;
                  default:            state_ff <= S_CLR;
               endcase
            end
            S_ADD: state_ff <= S_ADD2;  // head read in flight
            S_ADD2: begin
               if (edges_ff >= LW'(qspe_pkg::EDGES)) begin
                  rsp_ff <= '{req_ff.edge_from, {DW{1'b0}}, 1'b0, 1'b1};
               end else begin
                  tgt_mem[edges_ff[EW-1:0]]  <= req_ff.edge_to;
                  cost_mem[edges_ff[EW-1:0]] <= req_ff.edge_weight;
                  link_mem[edges_ff[EW-1:0]] <= head_rd_ff;
                  head_mem[req_ff.edge_from] <= edges_ff + 1'b1;
                  edges_ff <= edges_ff + 1'b1;
               end
               state_ff <= S_IDLE;
            end
            S_QRY: state_ff <= S_QRY2;
            S_QRY2: begin
               if ({1'b0, req_ff.edge_from} < n_act)
                  rsp_ff <= '{req_ff.edge_from, dist_rd_ff,
                              dist_rd_ff < qspe_pkg::INIT_DIST, 1'b0};
               else
                  rsp_ff <= '{req_ff.edge_from, qspe_pkg::INIT_DIST, 1'b0, 1'b0};
               state_ff <= S_IDLE;
            end
            S_INIT: begin
               // clear flags over all nodes, set active distances
               flag_mem[sweep_ff[NW-1:0]] <= 1'b0;
               if (sweep_ff < n_act)
                  dist_mem[sweep_ff[NW-1:0]] <= qspe_pkg::INIT_DIST;
               sweep_ff <= sweep_ff + 1'b1;
               if (sweep_ff[NW-1:0] == '1) state_ff <= S_SRC;
            end
            S_SRC: begin
               // seed the queue with the source; an inactive source ends the solve
               if ({1'b0, source_ff} < n_act) begin
                  dist_mem[source_ff]  <= '0;
                  flag_mem[source_ff]  <= 1'b1;
                  queue_mem[0]         <= source_ff;
                  rd_ff   <= '0;
                  wr_ff   <= NW'(1);
                  fill_ff <= (NW+1)'(1);
                  state_ff <= S_POP;
               end else
                  state_ff <= S_IDLE;
            end
            S_POP: begin
               // queue head read in flight
               if (fill_ff == '0) state_ff <= S_IDLE;
               else state_ff <= S_POPD;
            end
            S_POPD: begin
               now_ff   <= q_rd_ff;
               rd_ff    <= rd_ff + 1'b1;
               fill_ff  <= fill_ff - 1'b1;
               state_ff <= S_HEAD;
            end
            S_HEAD: begin
               // head/dist of now are registered here and arrive in S_LINK
               if ({1'b0, now_ff} >= n_act) state_ff <= S_POP;
               else state_ff <= S_LINK;
            end
            S_LINK: begin
               // latch the first edge of now and its distance
               link_ff  <= head_rd_ff;
               dnow_ff  <= dist_rd_ff;
               state_ff <= S_EDGE;
            end
            S_EDGE: begin
               if (!link_ok) begin
                  flag_mem[now_ff] <= 1'b0;
                  state_ff <= S_POP;
               end else
                  state_ff <= S_TGT;
            end
            S_TGT: begin
               // edge fields now valid; dist of target in flight
               cand_ff  <= qspe_pkg::sat_add(dnow_ff, cost_rd_ff);
               state_ff <= S_RELAX;
            end
            S_RELAX: begin
               if ({1'b0, tgt_rd_ff} < n_act && cand_ff < dist_rd_ff) begin
                  dist_mem[tgt_rd_ff] <= cand_ff;
                  if (!flag_rd_ff && fill_ff < (NW+1)'(qspe_pkg::NODES)) begin
                     queue_mem[wr_ff]    <= tgt_rd_ff;
                     wr_ff               <= wr_ff + 1'b1;
                     fill_ff             <= fill_ff + 1'b1;
                     flag_mem[tgt_rd_ff] <= 1'b1;
                  end
               end
               link_ff  <= link_rd_ff;
               state_ff <= S_EDGE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ===== hdl/qspe_csr.sv =====
// Configuration registers: source node and active node count.
module qspe_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [2:0]                    csr_paddr,
   input  logic [31:0]                   csr_pwdata,
   output logic [31:0]                   csr_prdata,
   output logic                          csr_pready,
   output logic [qspe_pkg::NODE_W-1:0]   source_ff,
   output logic [qspe_pkg::COUNT_W-1:0]  count_ff
);
   logic       wr;
   logic [0:0] idx;

   assign csr_pready = 1'b1;
   assign wr  = csr_psel & csr_penable & csr_pwrite;
   assign idx = csr_paddr[2:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         source_ff <= '0;
         count_ff  <= qspe_pkg::COUNT_W'(qspe_pkg::NODES);
      end else if (wr && csr_paddr[1:0] == 2'd0) begin
         if (idx == qspe_pkg::REG_SOURCE) source_ff <= csr_pwdata[qspe_pkg::NODE_W-1:0];
         else                             count_ff  <= csr_pwdata[qspe_pkg::COUNT_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (idx == qspe_pkg::REG_SOURCE)
         csr_prdata[qspe_pkg::NODE_W-1:0] = source_ff;
      else
         csr_prdata[qspe_pkg::COUNT_W-1:0] = count_ff;
   end
endmodule
